>>> src/brf_pkg.sv
// ---------------------------------------------------------------------------
// brf_pkg
// Shared request codes, widths and control types for the byte ring FIFO.
// ---------------------------------------------------------------------------
package brf_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam int REQ_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 9;

   localparam logic [REQ_W-1:0] REQ_PUT    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_GET    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SUBMIT = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

   // controller -> datapath
   typedef struct packed {
      logic load;    // transaction taken this cycle, execute it
   } brf_cmd_type;

endpackage

>>> src/brf_ctrl.sv
// ---------------------------------------------------------------------------
// brf_ctrl
// Handshake controller: tracks whether the result register holds an
// untaken result and decides when a new request may be taken.
// ---------------------------------------------------------------------------
module brf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output brf_pkg::brf_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   // a request may enter when the result slot is empty or drains this cycle
   assign req_stall = (state_ff == ST_HOLD) && rsp_stall;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_HOLD);
   assign cmd.load  = take;

   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = ST_HOLD;
      end else if ((state_ff == ST_HOLD) && !rsp_stall) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/brf_datapath.sv
// ---------------------------------------------------------------------------
// brf_datapath
// Byte store, the write/front/peek pointers and the result register.
// ---------------------------------------------------------------------------
module brf_datapath #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  brf_pkg::brf_cmd_type          cmd,
   input  logic [brf_pkg::REQ_W-1:0]     req_type,
   input  logic [brf_pkg::BYTE_W-1:0]    req_byte_in,
   input  logic                          req_burst_end,
   output logic [brf_pkg::BYTE_W-1:0]    rsp_byte_out,
   output logic                          rsp_accepted,
   output logic [brf_pkg::COUNT_W-1:0]   rsp_used_count,
   output logic [brf_pkg::COUNT_W-1:0]   rsp_unread_count,
   output logic                          rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int PTR_W = IDX_W + 1;
   localparam int EXT_W = (PTR_W > brf_pkg::COUNT_W) ? PTR_W : brf_pkg::COUNT_W;

   logic [brf_pkg::BYTE_W-1:0] mem_ff [DEPTH];

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] fp_ff, fp_in;
   logic [PTR_W-1:0] pp_ff, pp_in;

   logic [PTR_W-1:0] used_now;
   logic [PTR_W-1:0] unread_now;
   logic [PTR_W-1:0] used_nxt;
   logic [PTR_W-1:0] unread_nxt;
   logic [EXT_W-1:0] used_ext;
   logic [EXT_W-1:0] unread_ext;

   logic             acc;
   logic             do_write;
   logic             do_read;
   logic [IDX_W-1:0] rd_idx;

   logic [brf_pkg::BYTE_W-1:0]  rd_data_ff;
   logic                        rd_sel_ff;
   logic                        acc_ff;
   logic [brf_pkg::COUNT_W-1:0] used_ff;
   logic [brf_pkg::COUNT_W-1:0] unread_ff;
   logic                        last_ff;

   assign used_now   = wp_ff - fp_ff;
   assign unread_now = wp_ff - pp_ff;

   always_comb begin
      wp_in    = wp_ff;
      fp_in    = fp_ff;
      pp_in    = pp_ff;
      acc      = 1'b0;
      do_write = 1'b0;
      do_read  = 1'b0;
      rd_idx   = pp_ff[IDX_W-1:0];
      unique case (req_type)
         brf_pkg::REQ_PUT: begin
            if (used_now < PTR_W'(DEPTH)) begin
               do_write = 1'b1;
               wp_in    = wp_ff + PTR_W'(1);
               acc      = 1'b1;
            end
         end
         brf_pkg::REQ_GET: begin
            rd_idx = fp_ff[IDX_W-1:0];
            if (used_now != '0) begin
               do_read = 1'b1;
               fp_in   = fp_ff + PTR_W'(1);
               pp_in   = fp_ff + PTR_W'(1);
               acc     = 1'b1;
            end
         end
         brf_pkg::REQ_PEEK: begin
            if (unread_now != '0) begin
               do_read = 1'b1;
               pp_in   = pp_ff + PTR_W'(1);
               acc     = 1'b1;
            end
         end
         brf_pkg::REQ_SUBMIT: begin
            fp_in = pp_ff;
            acc   = 1'b1;
         end
         brf_pkg::REQ_CANCEL: begin
            pp_in = fp_ff;
            acc   = 1'b1;
         end
         brf_pkg::REQ_CLEAR: begin
            wp_in = '0;
            fp_in = '0;
            pp_in = '0;
            acc   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign used_nxt   = wp_in - fp_in;
   assign unread_nxt = wp_in - pp_in;
   assign used_ext   = EXT_W'(used_nxt);
   assign unread_ext = EXT_W'(unread_nxt);

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         fp_ff <= '0;
         pp_ff <= '0;
      end else if (cmd.load) begin
         wp_ff <= wp_in;
         fp_ff <= fp_in;
         pp_ff <= pp_in;
      end
   end

   // byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && do_write) begin
         mem_ff[wp_ff[IDX_W-1:0]] <= req_byte_in;
      end
      if (cmd.load) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   // result register, loaded only when a transaction is taken
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_sel_ff <= do_read;
         acc_ff    <= acc;
         used_ff   <= used_ext[brf_pkg::COUNT_W-1:0];
         unread_ff <= unread_ext[brf_pkg::COUNT_W-1:0];
         last_ff   <= req_burst_end;
      end
   end

   assign rsp_byte_out      = rd_sel_ff ? rd_data_ff : '0;
   assign rsp_accepted      = acc_ff;
   assign rsp_used_count    = used_ff;
   assign rsp_unread_count  = unread_ff;
   assign rsp_last          = last_ff;

endmodule

>>> src/byte_ring_fifo_with_peek_commit_unit.sv
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_peek_commit_unit
// Byte ring FIFO with committed front and speculative peek pointer.
// ---------------------------------------------------------------------------
// One request is taken per clock cycle; its result is presented on the rsp_
// channel the cycle after it is taken, because the byte store read is
// registered at the taking edge. The result register holds one result: while
// it is full and rsp_stall is high, req_stall is raised, otherwise a new
// request is taken in the same cycle the previous result leaves. Capacity is
// DEPTH bytes (a power of two from 2 to 65536); the counts on the result are
// the low 9 bits of the pointer distances. The store needs no clearing pass.
module byte_ring_fifo_with_peek_commit_unit #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [brf_pkg::REQ_W-1:0]     req_type,
   input  logic [brf_pkg::BYTE_W-1:0]    req_byte_in,
   input  logic                          req_burst_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brf_pkg::BYTE_W-1:0]    rsp_byte_out,
   output logic                          rsp_accepted,
   output logic [brf_pkg::COUNT_W-1:0]   rsp_used_count,
   output logic [brf_pkg::COUNT_W-1:0]   rsp_unread_count,
   output logic                          rsp_last
);

   brf_pkg::brf_cmd_type    cmd;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   brf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_byte_in      (req_byte_in),
      .req_burst_end    (req_burst_end),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_accepted     (rsp_accepted),
      .rsp_used_count   (rsp_used_count),
      .rsp_unread_count (rsp_unread_count),
      .rsp_last         (rsp_last)
   );

   // a taken transaction always shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("taken transaction produced no result");

   // result slot is never overwritten while its result waits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken over a stalled result");

   // a nonzero byte only comes from a successful get or peek
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_byte_out != '0)) |-> rsp_accepted)
      else $error("byte returned on a refused request");

   // peek never runs ahead of the write pointer or behind the front (checked for DEPTH up to 256)
   assert property (@(posedge clock) disable iff (reset)
      ((DEPTH <= 256) && rsp_valid) |-> (rsp_unread_count <= rsp_used_count))
      else $error("unread count exceeds used count");

endmodule
